[rtl/core/quorum_request_tracker_macros.svh]
// ----------------------------------------------------------------------------
// quorum_request_tracker assertion macros
// shared concurrent assertion helpers for the tracker rtl
// ----------------------------------------------------------------------------
`ifndef QUORUM_REQUEST_TRACKER_MACROS_SVH
`define QUORUM_REQUEST_TRACKER_MACROS_SVH

// property checked every clock edge outside reset
`define QRT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent, outside reset
`define QRT_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

[rtl/core/qrt_pkg.sv]
// ----------------------------------------------------------------------------
// qrt_pkg
// types and constants of the quorum request tracker
// ----------------------------------------------------------------------------
`default_nettype none

package qrt_pkg;

  // slot table geometry, slot count must be a power of two
  localparam int unsigned SLOTS  = 16;
  localparam int unsigned SLOT_W = $clog2(SLOTS);

  localparam int unsigned ID_W    = 16;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned TIME_W  = 16;
  localparam int unsigned CNT_W   = 3;
  localparam int unsigned TMO_W   = 8;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 8;

  localparam logic [CNT_W-1:0] CNT_MAX = 3'd7;

  // command codes
  localparam logic [1:0] CMD_ISSUE = 2'd0;
  localparam logic [1:0] CMD_REPLY = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  // outcome codes
  localparam logic [1:0] OUT_SUCCESS = 2'd0;
  localparam logic [1:0] OUT_FAIL    = 2'd1;
  localparam logic [1:0] OUT_REJECT  = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_QUORUM  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FAIL    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd2;

  // reset values of the registers
  localparam logic [CNT_W-1:0] QUORUM_RST  = 3'd2;
  localparam logic [CNT_W-1:0] FAIL_RST    = 3'd2;
  localparam logic [TMO_W-1:0] TIMEOUT_RST = 8'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REPLY,
    ST_SCAN,
    ST_FLUSH
  } state_e;

  typedef struct packed {
    logic [ID_W-1:0]   tag;
    logic [KIND_W-1:0] kind;
    logic [TIME_W-1:0] itime;
    logic [CNT_W-1:0]  rcnt;
    logic [CNT_W-1:0]  scnt;
  } slot_ent_t;

  typedef struct packed {
    logic [CNT_W-1:0] quorum;
    logic [CNT_W-1:0] fail_limit;
    logic [TMO_W-1:0] timeout;
  } cfg_t;

  typedef struct packed {
    logic             fail;
    logic             succ;
    logic [CNT_W-1:0] rcnt_inc;
    logic [CNT_W-1:0] scnt_inc;
  } eval_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [KIND_W-1:0] kind;
    logic [1:0]        outcome;
    logic              last;
  } result_t;

endpackage

`default_nettype wire

[rtl/core/qrt_if.sv]
// ----------------------------------------------------------------------------
// qrt_if
// valid/ready channel interfaces of the quorum request tracker
// ----------------------------------------------------------------------------
`default_nettype none

// request channel
interface qrt_req_if import qrt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        cmd;
  logic [ID_W-1:0]   trans_id;
  logic [KIND_W-1:0] op_kind;
  logic              reply_ok;

  modport source (output valid, cmd, trans_id, op_kind, reply_ok, input ready);
  modport sink   (input valid, cmd, trans_id, op_kind, reply_ok, output ready);
endinterface

// result channel
interface qrt_res_if import qrt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ID_W-1:0]   done_id;
  logic [KIND_W-1:0] done_kind;
  logic [1:0]        outcome;
  logic              last;

  modport source (output valid, done_id, done_kind, outcome, last, input ready);
  modport sink   (input valid, done_id, done_kind, outcome, last, output ready);
endinterface

// register write channel
interface qrt_cfg_if import qrt_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[rtl/core/qrt_slot_mem.sv]
// ----------------------------------------------------------------------------
// qrt_slot_mem
// slot table storage, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module qrt_slot_mem import qrt_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [SLOT_W-1:0] waddr_i,
  input  wire slot_ent_t         wdata_i,
  input  wire logic              re_i,
  input  wire logic [SLOT_W-1:0] raddr_i,
  output slot_ent_t              rdata_o
);

  slot_ent_t mem_q [SLOTS];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port, data holds while no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

[rtl/core/qrt_eval.sv]
// ----------------------------------------------------------------------------
// qrt_eval
// shared slot evaluation unit: finish tests and counter updates
// ----------------------------------------------------------------------------
`default_nettype none

module qrt_eval import qrt_pkg::*; (
  input  wire slot_ent_t         ent_i,
  input  wire cfg_t              cfg_i,
  input  wire logic [TIME_W-1:0] time_i,
  input  wire logic              ok_i,
  output eval_t                  res_o
);

  logic [CNT_W-1:0]  unsucc;
  logic [TIME_W-1:0] age;

  // unsuccessful replies, clamped at zero
  assign unsucc = (ent_i.rcnt >= ent_i.scnt) ? (ent_i.rcnt - ent_i.scnt) : '0;

  // age wraps with time
  assign age = time_i - ent_i.itime;

  always_comb begin
    res_o.fail = (unsucc >= cfg_i.fail_limit) ||
                 (age > {{(TIME_W-TMO_W){1'b0}}, cfg_i.timeout});
    res_o.succ = (ent_i.scnt >= cfg_i.quorum);
    // saturating counters for a reply
    res_o.rcnt_inc = (ent_i.rcnt == CNT_MAX) ? CNT_MAX : ent_i.rcnt + 1'b1;
    res_o.scnt_inc = (ok_i && ent_i.scnt != CNT_MAX) ? ent_i.scnt + 1'b1 : ent_i.scnt;
  end

endmodule

`default_nettype wire

[rtl/core/quorum_request_tracker.sv]
// ----------------------------------------------------------------------------
// quorum_request_tracker
// table of outstanding replicated requests with quorum and timeout decisions
// ----------------------------------------------------------------------------
// usage:
//   req_i carries commands: issue (store a request in slot trans_id mod SLOTS),
//   reply (count a replica answer) and tick (scan all slots, then advance time).
//   res_o returns finished or rejected requests; last marks the final result
//   that one command causes. cfg_i writes quorum_needed, fail_limit and
//   timeout_ticks at indexes 0, 1 and 2 and is always ready.
// sequence:
//   an issue keeps the tracker idle, a rejected issue goes through the flush
//   state before the next command. a reply reads its slot when accepted and
//   writes it back in the reply state. a tick reads slot 0 when accepted,
//   scans one slot per cycle through the read port and the shared evaluation
//   unit unless the scan stalls, then hands the last result on with last set
//   in the flush state. a found result waits in a holding register until the
//   next one is found or the scan ends, then moves to res_o; the scan stalls
//   only when a result is found while holding register and res_o are full.
// reset:
//   all slots free, time zero, registers at 2, 2 and 4; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

`include "quorum_request_tracker_macros.svh"

module quorum_request_tracker import qrt_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  qrt_req_if.sink   req_i,
  qrt_res_if.source res_o,
  qrt_cfg_if.sink   cfg_i
);

  state_e              state_q, state_d;
  logic [SLOTS-1:0]    busy_q, busy_d;
  logic [TIME_W-1:0]   time_now_q, time_now_d;
  cfg_t                cfg_q;
  logic [SLOT_W-1:0]   idx_q, idx_d;
  logic [SLOT_W-1:0]   slot_q, slot_d;
  logic [ID_W-1:0]     id_q, id_d;
  logic                ok_q, ok_d;
  result_t             hold_q, hold_d;
  logic                hold_valid_q, hold_valid_d;
  result_t             out_q, out_d;
  logic                out_valid_q, out_valid_d;

  logic                acc_in;
  logic [SLOT_W-1:0]   slot_in;
  logic                out_free;
  logic                scan_last;
  logic                scan_fin;
  logic                scan_adv;
  logic                reply_hit;

  logic                mem_we, mem_re;
  logic [SLOT_W-1:0]   mem_waddr, mem_raddr;
  slot_ent_t           mem_wdata, mem_rdata;
  eval_t               ev;

  // handshake helpers
  assign req_i.ready = (state_q == ST_IDLE);
  assign acc_in      = req_i.valid && req_i.ready;
  assign slot_in     = req_i.trans_id[SLOT_W-1:0];
  assign out_free    = !out_valid_q || res_o.ready;
  assign cfg_i.ready = 1'b1;

  // scan step status
  assign scan_last = (idx_q == SLOT_W'(SLOTS - 1));
  assign scan_fin  = busy_q[idx_q] && (ev.fail || ev.succ);
  assign scan_adv  = !(scan_fin && hold_valid_q && !out_free);
  assign reply_hit = busy_q[slot_q] && (mem_rdata.tag == id_q);

  qrt_slot_mem u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  qrt_eval u_eval (
    .ent_i  (mem_rdata),
    .cfg_i  (cfg_q),
    .time_i (time_now_q),
    .ok_i   (ok_q),
    .res_o  (ev)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (acc_in) begin
          case (req_i.cmd)
            CMD_ISSUE: if (busy_q[slot_in]) state_d = ST_FLUSH;
            CMD_REPLY: state_d = ST_REPLY;
            CMD_TICK:  state_d = ST_SCAN;
            default:   state_d = ST_IDLE;
          endcase
        end
      end
      ST_REPLY: state_d = ST_IDLE;
      ST_SCAN: begin
        if (scan_adv && scan_last) state_d = ST_FLUSH;
      end
      ST_FLUSH: begin
        if (!hold_valid_q || out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    busy_d       = busy_q;
    time_now_d   = time_now_q;
    idx_d        = idx_q;
    slot_d       = slot_q;
    id_d         = id_q;
    ok_d         = ok_q;
    hold_d       = hold_q;
    hold_valid_d = hold_valid_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q && !res_o.ready;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    mem_waddr    = slot_in;
    mem_raddr    = slot_in;
    mem_wdata    = mem_rdata;
    case (state_q)
      ST_IDLE: begin
        slot_d = slot_in;
        id_d   = req_i.trans_id;
        ok_d   = req_i.reply_ok;
        idx_d  = '0;
        if (acc_in) begin
          case (req_i.cmd)
            CMD_ISSUE: begin
              if (busy_q[slot_in]) begin
                // occupied slot, report the new request as rejected
                hold_d       = '{id: req_i.trans_id, kind: req_i.op_kind,
                                 outcome: OUT_REJECT, last: 1'b1};
                hold_valid_d = 1'b1;
              end else begin
                mem_we          = 1'b1;
                mem_wdata.tag   = req_i.trans_id;
                mem_wdata.kind  = req_i.op_kind;
                mem_wdata.itime = time_now_q;
                mem_wdata.rcnt  = '0;
                mem_wdata.scnt  = '0;
                busy_d[slot_in] = 1'b1;
              end
            end
            CMD_REPLY: mem_re = 1'b1;
            CMD_TICK: begin
              mem_re    = 1'b1;
              mem_raddr = '0;
            end
            default: ;
          endcase
        end
      end
      ST_REPLY: begin
        // write back updated counters on a tag match
        mem_waddr      = slot_q;
        mem_we         = reply_hit;
        mem_wdata.rcnt = ev.rcnt_inc;
        mem_wdata.scnt = ev.scnt_inc;
      end
      ST_SCAN: begin
        mem_raddr = idx_q + 1'b1;
        if (scan_adv) begin
          if (scan_fin) begin
            if (hold_valid_q) begin
              out_d       = hold_q;
              out_valid_d = 1'b1;
            end
            hold_d       = '{id: mem_rdata.tag, kind: mem_rdata.kind,
                             outcome: ev.fail ? OUT_FAIL : OUT_SUCCESS, last: 1'b0};
            hold_valid_d = 1'b1;
            busy_d[idx_q] = 1'b0;
          end
          if (scan_last) begin
            time_now_d = time_now_q + 1'b1;
          end else begin
            mem_re = 1'b1;
            idx_d  = idx_q + 1'b1;
          end
        end
      end
      ST_FLUSH: begin
        // final held result of this command carries last
        if (hold_valid_q && out_free) begin
          out_d        = hold_q;
          out_d.last   = 1'b1;
          out_valid_d  = 1'b1;
          hold_valid_d = 1'b0;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      busy_q       <= '0;
      time_now_q   <= '0;
      hold_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      idx_q        <= '0;
    end else begin
      state_q      <= state_d;
      busy_q       <= busy_d;
      time_now_q   <= time_now_d;
      hold_valid_q <= hold_valid_d;
      out_valid_q  <= out_valid_d;
      idx_q        <= idx_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
    id_q   <= id_d;
    ok_q   <= ok_d;
    hold_q <= hold_d;
    out_q  <= out_d;
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.quorum     <= QUORUM_RST;
      cfg_q.fail_limit <= FAIL_RST;
      cfg_q.timeout    <= TIMEOUT_RST;
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (cfg_i.index)
        CFG_QUORUM:  cfg_q.quorum     <= cfg_i.data[CNT_W-1:0];
        CFG_FAIL:    cfg_q.fail_limit <= cfg_i.data[CNT_W-1:0];
        CFG_TIMEOUT: cfg_q.timeout    <= cfg_i.data[TMO_W-1:0];
        default: ;
      endcase
    end
  end

  // result channel
  assign res_o.valid     = out_valid_q;
  assign res_o.done_id   = out_q.id;
  assign res_o.done_kind = out_q.kind;
  assign res_o.outcome   = out_q.outcome;
  assign res_o.last      = out_q.last;

  // assertions
  `QRT_ASSERT(a_idle_no_hold, (state_q == ST_IDLE) |-> !hold_valid_q,
    "held result left over in idle")
  `QRT_ASSERT_NEXT(a_tick_scans, acc_in && (req_i.cmd == CMD_TICK), state_q == ST_SCAN,
    "tick did not start a scan")
  `QRT_ASSERT_NEXT(a_issue_sets_busy,
    acc_in && (req_i.cmd == CMD_ISSUE) && !busy_q[slot_in], busy_q[$past(slot_in)],
    "accepted issue did not occupy its slot")
  `QRT_ASSERT(a_time_at_scan_end,
    (time_now_q != $past(time_now_q)) |-> ($past(state_q) == ST_SCAN),
    "time advanced outside a scan")

endmodule

`default_nettype wire
